// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ERT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ert assertion failed");

`define ERT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ert assertion failed");

`define ERT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ert assertion failed");

`else

`define ERT_ASSERT_ALWAYS(lbl, expr)
`define ERT_ASSERT_IMPLY(lbl, ante, cons)
`define ERT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/ert_pkg.sv =====
package ert_pkg;

  localparam int Entries = 16;
  localparam int IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW    = $clog2(Entries + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_BASE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] base;
    logic [7:0]  last_bus;
    logic [7:0]  first_bus;
    logic [15:0] segment_number;
  } entry_t;

  typedef struct packed {
    logic       upd;
    entry_t     key;
    logic [7:0] query_bus;
  } bcast_t;

endpackage

// ===== sv/ert_cell.sv =====
module ert_cell (
  input  logic            clk,
  input  ert_pkg::bcast_t bc,
  input  logic            occ,
  input  logic            prev_ge,
  input  ert_pkg::entry_t prev_entry,
  output logic            ge,
  output logic            match,
  output ert_pkg::entry_t entry
);

  ert_pkg::entry_t entry_r;
  ert_pkg::entry_t entry_nxt;

  assign ge = !occ
           || (entry_r.segment_number > bc.key.segment_number)
           || ((entry_r.segment_number == bc.key.segment_number)
               && (entry_r.first_bus >= bc.key.first_bus));

  assign match = occ
              && (entry_r.segment_number == bc.key.segment_number)
              && (entry_r.first_bus <= bc.query_bus)
              && (bc.query_bus <= entry_r.last_bus);

  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (bc.upd && ge) begin
      entry_nxt = prev_ge ? prev_entry : bc.key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== sv/ert_sel.sv =====
module ert_sel (
  input  logic [ert_pkg::Entries-1:0]    match,
  input  ert_pkg::entry_t                entries [ert_pkg::Entries],
  output logic                           hit,
  output logic [ert_pkg::IdxW-1:0]       idx,
  output ert_pkg::entry_t                entry
);

  logic [ert_pkg::Entries-1:0] first;

  assign first = match & (~match + ert_pkg::Entries'(1));
  assign hit   = |match;

  always_comb begin
    idx   = '0;
    entry = '0;
    for (int k = 0; k < ert_pkg::Entries; k++) begin
      if (first[k]) begin
        idx   = idx | ert_pkg::IdxW'(k);
        entry = entry | entries[k];
      end
    end
  end

endmodule

// ===== sv/ecam_region_table_core.sv =====
// Insert steps: accept, then compare and shift.
// Lookup steps: accept, compare in every cell, first-match select.
// One request is in flight at a time; the next is taken once the result sits
// in the output register, so requests never overlap.
// Reset empties the table (entry count to zero) and drops any pending result.
`include "assert_macros.svh"

module ecam_region_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] segment_number, [23:16] first_bus, [31:24] last_bus,
  // [95:32] window_base, [103:96] query_bus
  input  logic [103:0] in_tdata,
  // [0] mode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [2] hit, [6:3] hit_index, [70:7] hit_base,
  // [78:71] hit_first_bus, [86:79] hit_last_bus, [87] zero
  output logic [87:0]  out_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PICK
  } state_t;

  state_t                       state_r;
  logic [ert_pkg::CntW-1:0]     cnt_r;
  logic                         mode_r;
  ert_pkg::entry_t              key_r;
  logic [7:0]                   bus_r;
  logic [ert_pkg::Entries-1:0]  match_r;
  logic                         out_valid_r;
  ert_pkg::status_t             out_status_r;
  logic                         out_hit_r;
  logic [3:0]                   out_idx_r;
  ert_pkg::entry_t              out_entry_r;

  ert_pkg::bcast_t              bc;
  ert_pkg::status_t             ins_status;
  logic                         out_free;
  logic                         ins_fire;
  logic                         out_load;
  logic [ert_pkg::Entries-1:0]  occ;
  logic [ert_pkg::Entries-1:0]  ge;
  logic [ert_pkg::Entries-1:0]  match;
  ert_pkg::entry_t              ents [ert_pkg::Entries];
  logic                         sel_hit;
  logic [ert_pkg::IdxW-1:0]     sel_idx;
  logic [ert_pkg::IdxW+3:0]     sel_idx_ext;
  ert_pkg::entry_t              sel_entry;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (key_r.base == 64'd0) begin
      ins_status = ert_pkg::ST_ZERO_BASE;
    end else if (cnt_r == ert_pkg::CntW'(ert_pkg::Entries)) begin
      ins_status = ert_pkg::ST_FULL;
    end else begin
      ins_status = ert_pkg::ST_OK;
    end
  end

  assign ins_fire     = (state_r == S_EXEC) && (mode_r == ert_pkg::MODE_INSERT) && out_free;
  assign out_load     = ins_fire || ((state_r == S_PICK) && out_free);

  assign bc.upd       = ins_fire && (ins_status == ert_pkg::ST_OK);
  assign bc.key       = key_r;
  assign bc.query_bus = bus_r;

  genvar k;
  generate
    for (k = 0; k < ert_pkg::Entries; k++) begin : g_cell
      assign occ[k] = (cnt_r > ert_pkg::CntW'(k));
      if (k == 0) begin : g_head
        ert_cell u_cell (
          .clk        (clk),
          .bc         (bc),
          .occ        (occ[k]),
          .prev_ge    (1'b0),
          .prev_entry (key_r),
          .ge         (ge[k]),
          .match      (match[k]),
          .entry      (ents[k])
        );
      end else begin : g_body
        ert_cell u_cell (
          .clk        (clk),
          .bc         (bc),
          .occ        (occ[k]),
          .prev_ge    (ge[k-1]),
          .prev_entry (ents[k-1]),
          .ge         (ge[k]),
          .match      (match[k]),
          .entry      (ents[k])
        );
      end
    end
  endgenerate

  ert_sel u_sel (
    .match   (match_r),
    .entries (ents),
    .hit     (sel_hit),
    .idx     (sel_idx),
    .entry   (sel_entry)
  );

  assign sel_idx_ext = {4'd0, sel_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r                 <= in_tuser[0];
            key_r.segment_number   <= in_tdata[15:0];
            key_r.first_bus        <= in_tdata[23:16];
            key_r.last_bus         <= in_tdata[31:24];
            key_r.base             <= in_tdata[95:32];
            bus_r                  <= in_tdata[103:96];
            state_r                <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (mode_r == ert_pkg::MODE_LOOKUP) begin
            match_r <= match;
            state_r <= S_PICK;
          end else if (out_free) begin
            out_status_r <= ins_status;
            out_hit_r    <= 1'b0;
            out_idx_r    <= 4'd0;
            out_entry_r  <= '0;
            if (ins_status == ert_pkg::ST_OK) begin
              cnt_r <= cnt_r + ert_pkg::CntW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        S_PICK: begin
          if (out_free) begin
            out_status_r <= ert_pkg::ST_OK;
            out_hit_r    <= sel_hit;
            out_idx_r    <= sel_idx_ext[3:0];
            out_entry_r  <= sel_entry;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_entry_r.last_bus, out_entry_r.first_bus,
                       out_entry_r.base, out_idx_r, out_hit_r, out_status_r};

  `ERT_ASSERT_ALWAYS(a_cnt_range, cnt_r <= ert_pkg::CntW'(ert_pkg::Entries))
  `ERT_ASSERT_NEXT(a_ins_grow, bc.upd, cnt_r == ert_pkg::CntW'($past(cnt_r) + 1'b1))
  `ERT_ASSERT_NEXT(a_refuse_hold, ins_fire && (ins_status != ert_pkg::ST_OK), $stable(cnt_r))
  `ERT_ASSERT_IMPLY(a_hit_ok, out_valid_r && out_hit_r, out_status_r == ert_pkg::ST_OK)
  `ERT_ASSERT_IMPLY(a_busy_stall, state_r != S_IDLE, !in_tready)

endmodule
